[rtl/hblp_pkg.sv]
// Shared types, codes and defaults of the hex byte list parser.
package hblp_pkg;

    localparam int unsigned COUNT_LIMIT_DEFAULT = 65535;
    localparam int unsigned MAX_BYTES_RESET     = 65535;
    localparam int unsigned QUEUE_DEPTH         = 4;

    // Parser modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_ZERO    = 3'd1;
    localparam logic [2:0] MODE_PREFIX  = 3'd2;
    localparam logic [2:0] MODE_ONE     = 3'd3;
    localparam logic [2:0] MODE_NEEDSEP = 3'd4;
    localparam logic [2:0] MODE_ERROR   = 3'd5;

    // Result outcomes
    localparam logic [1:0] OUTCOME_BYTE  = 2'd0;
    localparam logic [1:0] OUTCOME_DONE  = 2'd1;
    localparam logic [1:0] OUTCOME_ERROR = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [7:0]  byte_value;
        logic [15:0] byte_count;
        logic        final_of_string;
    } result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  held;
        logic [15:0] count;
    } parse_state_t;

endpackage

[rtl/hblp_ifs.sv]
// Valid/ready channel interfaces for characters and results.
interface hblp_ch_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface hblp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [7:0]  byte_value;
    logic [15:0] byte_count;
    logic        final_of_string;

    modport source (output valid, output outcome, output byte_value, output byte_count,
                    output final_of_string, input ready);
    modport sink   (input valid, input outcome, input byte_value, input byte_count,
                    input final_of_string, output ready);
endinterface

[rtl/hblp_step.sv]
// Per-character parse step: next state and up to two results.
module hblp_step
    import hblp_pkg::*;
(
    input  parse_state_t state,
    input  logic [15:0]  limit,
    input  logic [7:0]   ch,
    output parse_state_t state_next,
    output logic [1:0]   n_res,
    output result_t      res0,
    output result_t      res1
);

    logic       is_dig;
    logic [3:0] dig;
    logic       is_sep;
    logic       is_nul;
    logic       room;
    logic [15:0] count_inc;
    result_t    err_res;
    result_t    done_res;

    always_comb
    begin
        is_dig = 1'b1;
        dig    = 4'd0;
        priority if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            dig = 4'(ch - CH_ZERO);
        end
        else if (ch >= CH_LOW_A && ch <= CH_LOW_F)
        begin
            dig = 4'(ch - CH_LOW_A + 8'd10);
        end
        else if (ch >= CH_UP_A && ch <= CH_UP_F)
        begin
            dig = 4'(ch - CH_UP_A + 8'd10);
        end
        else
        begin
            is_dig = 1'b0;
        end
    end

    assign is_sep    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_COMMA);
    assign is_nul    = (ch == CH_NUL);
    assign room      = (state.count < limit);
    assign count_inc = state.count + 16'd1;

    always_comb
    begin
        err_res  = '{outcome: OUTCOME_ERROR, byte_value: 8'd0,
                     byte_count: state.count, final_of_string: 1'b1};
        done_res = '{outcome: OUTCOME_DONE, byte_value: 8'd0,
                     byte_count: state.count, final_of_string: 1'b1};
    end

    always_comb
    begin
        state_next = state;
        n_res      = 2'd0;
        res0       = err_res;
        res1       = err_res;

        unique case (state.mode)
            MODE_ERROR:
            begin
                if (is_nul)
                begin
                    state_next = '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0};
                end
            end
            MODE_PREFIX:
            begin
                if (is_dig)
                begin
                    state_next.mode = MODE_ONE;
                    state_next.held = dig;
                end
                else
                begin
                    n_res      = 2'd1;
                    state_next = is_nul ? '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0}
                                        : '{mode: MODE_ERROR, held: 4'd0, count: state.count};
                end
            end
            MODE_ZERO, MODE_ONE:
            begin
                if (state.mode == MODE_ZERO && (ch == CH_LOW_X || ch == CH_UP_X))
                begin
                    state_next.mode = MODE_PREFIX;
                end
                else if (!room)
                begin
                    // Byte would pass the limit: error instead
                    n_res      = 2'd1;
                    state_next = is_nul ? '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0}
                                        : '{mode: MODE_ERROR, held: 4'd0, count: state.count};
                end
                else if (is_dig)
                begin
                    n_res      = 2'd1;
                    res0       = '{outcome: OUTCOME_BYTE, byte_value: {state.held, dig},
                                   byte_count: count_inc, final_of_string: 1'b0};
                    state_next = '{mode: MODE_NEEDSEP, held: 4'd0, count: count_inc};
                end
                else
                begin
                    // One-digit byte closed by the current character
                    n_res = 2'd1;
                    res0  = '{outcome: OUTCOME_BYTE, byte_value: {4'd0, state.held},
                              byte_count: count_inc, final_of_string: 1'b0};
                    res1  = '{outcome: OUTCOME_ERROR, byte_value: 8'd0,
                              byte_count: count_inc, final_of_string: 1'b1};
                    if (is_nul)
                    begin
                        n_res          = 2'd2;
                        res1.outcome   = OUTCOME_DONE;
                        state_next     = '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0};
                    end
                    else if (is_sep)
                    begin
                        state_next = '{mode: MODE_BETWEEN, held: 4'd0, count: count_inc};
                    end
                    else
                    begin
                        n_res      = 2'd2;
                        state_next = '{mode: MODE_ERROR, held: 4'd0, count: count_inc};
                    end
                end
            end
            MODE_NEEDSEP:
            begin
                if (is_nul)
                begin
                    n_res      = 2'd1;
                    res0       = done_res;
                    state_next = '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0};
                end
                else if (is_sep)
                begin
                    state_next.mode = MODE_BETWEEN;
                end
                else
                begin
                    n_res      = 2'd1;
                    state_next = '{mode: MODE_ERROR, held: 4'd0, count: state.count};
                end
            end
            default:
            begin
                // Between tokens; unused codes land here too
                state_next.mode = MODE_BETWEEN;
                if (is_nul)
                begin
                    n_res      = 2'd1;
                    res0       = done_res;
                    state_next = '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0};
                end
                else if (is_sep)
                begin
                    state_next.mode = MODE_BETWEEN;
                end
                else if (is_dig)
                begin
                    state_next.mode = (ch == CH_ZERO) ? MODE_ZERO : MODE_ONE;
                    state_next.held = dig;
                end
                else
                begin
                    n_res      = 2'd1;
                    state_next = '{mode: MODE_ERROR, held: 4'd0, count: state.count};
                end
            end
        endcase
    end

endmodule

[rtl/hblp_queue.sv]
// Small result queue: takes up to two results a cycle, releases one.
module hblp_queue
    import hblp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  result_t           push0,
    input  result_t           push1,
    output logic              room2,
    hblp_res_if.source        res_out
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   wr_plus1;
    logic            pop;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    assign pop      = res_out.valid && res_out.ready;
    assign wr_plus1 = wrap_inc(wr_reg);
    assign room2    = (cnt_reg <= CW'(DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = pop ? wrap_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push_n) - CW'(pop);
        unique case (push_n)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = wrap_inc(wr_plus1);
            default: wr_next = wr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_plus1] <= push1;
        end
    end

    assign res_out.valid           = (cnt_reg != '0);
    assign res_out.outcome         = mem_reg[rd_reg].outcome;
    assign res_out.byte_value      = mem_reg[rd_reg].byte_value;
    assign res_out.byte_count      = mem_reg[rd_reg].byte_count;
    assign res_out.final_of_string = mem_reg[rd_reg].final_of_string;

endmodule

[rtl/hex_byte_list_parser.sv]
// Top level of the streaming hex byte list parser.
//
// Characters arrive on ch_in, one per transaction; a NUL (0) ends a string.
// Results leave on res_out, one per transaction: a parsed byte, a done
// marker with the byte count, or a single error marker. A consumer must
// discard the bytes of a string that ends in error.
// cfg_we/cfg_wdata write max_bytes; write only while the block is idle.
// The limit in force is the smaller of max_bytes and COUNT_LIMIT.
//
// An accepted character is held in the input stage and parsed there once
// the result queue has room for two results; its results are written into
// the queue, which offers them on res_out. Throughput: one character per
// cycle while the queue has that room. A character that closes a one-digit
// token together with a NUL or a bad character yields two results, which
// res_out releases one per transaction; the four-entry queue absorbs them.
// Reset clears the parser to "between tokens", the byte count to zero, the
// limit to its default, and empties the input stage and the result queue.
// A stalled receiver fills the queue; the parse stage then holds its
// character and ch_in.ready drops until room for two results opens.
module hex_byte_list_parser
    import hblp_pkg::*;
#(
    parameter int unsigned COUNT_LIMIT = COUNT_LIMIT_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    hblp_ch_if.sink      ch_in,
    hblp_res_if.source   res_out
);

    localparam logic [15:0] LIMIT_CAP = 16'(COUNT_LIMIT);
    localparam logic [15:0] LIMIT_RST =
        (16'(MAX_BYTES_RESET) < LIMIT_CAP) ? 16'(MAX_BYTES_RESET) : LIMIT_CAP;

    // Input stage
    logic [7:0]   ch_reg;
    logic         full_reg, full_next;

    // Parser state and limit in force
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [15:0]  limit_reg;

    logic         room2;
    logic         step_go;
    logic         take;
    logic [1:0]   n_res;
    logic [1:0]   push_n;
    result_t      res0;
    result_t      res1;

    // Parse the held character once the queue can absorb its worst case
    assign step_go     = full_reg && room2;
    assign ch_in.ready = !full_reg || step_go;
    assign take        = ch_in.valid && ch_in.ready;
    assign push_n      = step_go ? n_res : 2'd0;

    always_comb
    begin
        priority if (take)
        begin
            full_next = 1'b1;
        end
        else if (step_go)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            state_reg <= '{mode: MODE_BETWEEN, held: 4'd0, count: 16'd0};
            limit_reg <= LIMIT_RST;
        end
        else
        begin
            full_reg <= full_next;
            if (step_go)
            begin
                state_reg <= state_next;
            end
            // Clamp the written limit to the build-time cap
            if (cfg_we)
            begin
                limit_reg <= (cfg_wdata < LIMIT_CAP) ? cfg_wdata : LIMIT_CAP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg <= ch_in.ch;
        end
    end

    hblp_step u_step (
        .state      (state_reg),
        .limit      (limit_reg),
        .ch         (ch_reg),
        .state_next (state_next),
        .n_res      (n_res),
        .res0       (res0),
        .res1       (res1)
    );

    hblp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_n  (push_n),
        .push0   (res0),
        .push1   (res1),
        .room2   (room2),
        .res_out (res_out)
    );

endmodule

[tb/sv/hex_byte_list_parser_tb.sv]
// Self-checking testbench for the hex byte list parser: directed table, then random strings.
module hex_byte_list_parser_tb;
    import hblp_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int SETTLE_CYCLES   = 4;       // lets the last character clear the pipeline
    localparam int HOLD_OFF_CYCLES = 60;      // long enough to fill the result queue
    localparam int IDLE_PERCENT    = 11;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_CHARS    = 1300;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int DIRECTED_COUNT  = 27;

    localparam result_t NO_RESULT = '0;

    // One row of the directed table. Where typed is set, the expected results are
    // written out in the row; otherwise the predictor supplies them.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [1:0] n_results;
        result_t    first;
        result_t    second;
    } char_row_t;

    localparam char_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty string right after reset: done with no bytes
        '{CH_NUL,   1'b1, 2'd1, '{OUTCOME_DONE, 8'h00, 16'd0, 1'b1}, NO_RESULT},
        // lone zero closed by NUL: byte 0, then done, in one step
        '{CH_ZERO,  1'b1, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_NUL,   1'b1, 2'd2, '{OUTCOME_BYTE, 8'h00, 16'd1, 1'b0},
                                '{OUTCOME_DONE, 8'h00, 16'd1, 1'b1}},
        // "0xFf", tab, "0X," : prefix with no digit ends in error
        '{CH_ZERO,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LOW_X, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_UP_F,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LOW_F, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_TAB,   1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_ZERO,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_UP_X,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_COMMA, 1'b1, 2'd1, '{OUTCOME_ERROR, 8'h00, 16'd1, 1'b1}, NO_RESULT},
        // NUL after an error is swallowed
        '{CH_NUL,   1'b1, 2'd0, NO_RESULT, NO_RESULT},
        // "9A a" then 0xFF: one digit then junk gives the byte and the error together
        '{CH_NINE,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_UP_A,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_SPACE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LOW_A, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'hFF,    1'b1, 2'd2, '{OUTCOME_BYTE,  8'h0A, 16'd2, 1'b0},
                                '{OUTCOME_ERROR, 8'h00, 16'd2, 1'b1}},
        '{CH_NUL,   1'b1, 2'd0, NO_RESULT, NO_RESULT},
        // "053": zero as high digit, then a missing separator
        '{CH_ZERO,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'h35,    1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'h33,    1'b1, 2'd1, '{OUTCOME_ERROR, 8'h00, 16'd1, 1'b1}, NO_RESULT},
        '{CH_NUL,   1'b1, 2'd0, NO_RESULT, NO_RESULT},
        // "0x" closed by NUL: error on the NUL itself, next character starts fresh
        '{CH_ZERO,  1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_LOW_X, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_NUL,   1'b1, 2'd1, '{OUTCOME_ERROR, 8'h00, 16'd0, 1'b1}, NO_RESULT},
        // "7": one digit closed by NUL
        '{8'h37,    1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_NUL,   1'b0, 2'd0, NO_RESULT, NO_RESULT}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    hblp_ch_if  ch_bus ();
    hblp_res_if res_bus ();

    hex_byte_list_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ch_in     (ch_bus),
        .res_out   (res_bus)
    );

    // Parser state as the testbench sees it
    logic [2:0]  parse_mode;
    logic [3:0]  held_nibble;
    logic [15:0] byte_total;
    logic [15:0] max_bytes_cfg;

    result_t char_results [$];     // results of the character just parsed
    result_t pending_results [$];  // results still owed by the block, oldest first

    int  mismatch_count;
    int  chars_sent;
    bit  idle_on;
    int  hold_off_asked;
    int  hold_off_served;
    int  hold_left;

    result_t want;
    result_t got;

    //--------------------------------------------------------------------
    // Clock
    //--------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or drops results
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("** hex_byte_list_parser: FAILED **");
        $finish;
    end

    //--------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------
    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_F)
            return 10 + int'(c - CH_LOW_A);
        if (c >= CH_UP_A && c <= CH_UP_F)
            return 10 + int'(c - CH_UP_A);
        return -1;
    endfunction

    function automatic bit is_separator(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_COMMA;
    endfunction

    // Error ends the string; a NUL error starts the next string at once,
    // anything else drops characters up to the next NUL.
    function automatic void raise_error(input logic [7:0] c);
        char_results.push_back(result_t'{OUTCOME_ERROR, 8'h00, byte_total, 1'b1});
        if (c == CH_NUL)
        begin
            parse_mode = MODE_BETWEEN;
            byte_total = '0;
        end
        else
        begin
            parse_mode = MODE_ERROR;
        end
        held_nibble = '0;
    endfunction

    function automatic void close_string();
        char_results.push_back(result_t'{OUTCOME_DONE, 8'h00, byte_total, 1'b1});
        parse_mode  = MODE_BETWEEN;
        byte_total  = '0;
        held_nibble = '0;
    endfunction

    // Emit a byte unless the limit is reached; report whether it went out.
    function automatic bit emit_byte(input logic [7:0] v);
        logic [15:0] cap;
        cap = (max_bytes_cfg < COUNT_LIMIT_DEFAULT) ? max_bytes_cfg
                                                    : 16'(COUNT_LIMIT_DEFAULT);
        if (byte_total >= cap)
            return 1'b0;
        byte_total = byte_total + 16'd1;
        char_results.push_back(result_t'{OUTCOME_BYTE, v, byte_total, 1'b0});
        return 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        int digit;
        digit = hex_value(c);
        char_results.delete();
        if (parse_mode > MODE_ERROR)
            parse_mode = MODE_BETWEEN;
        case (parse_mode)
            MODE_ERROR:
            begin
                if (c == CH_NUL)
                begin
                    parse_mode  = MODE_BETWEEN;
                    byte_total  = '0;
                    held_nibble = '0;
                end
            end
            MODE_BETWEEN:
            begin
                if (c == CH_NUL)
                    close_string();
                else if (is_separator(c))
                    ;
                else if (c == CH_ZERO)
                begin
                    held_nibble = '0;
                    parse_mode  = MODE_ZERO;
                end
                else if (digit >= 0)
                begin
                    held_nibble = 4'(digit);
                    parse_mode  = MODE_ONE;
                end
                else
                    raise_error(c);
            end
            MODE_PREFIX:
            begin
                if (digit >= 0)
                begin
                    held_nibble = 4'(digit);
                    parse_mode  = MODE_ONE;
                end
                else
                    raise_error(c);
            end
            MODE_ZERO, MODE_ONE:
            begin
                if (parse_mode == MODE_ZERO && (c == CH_LOW_X || c == CH_UP_X))
                    parse_mode = MODE_PREFIX;
                else if (digit >= 0)
                begin
                    if (!emit_byte({held_nibble, 4'(digit)}))
                        raise_error(c);
                    else
                    begin
                        parse_mode  = MODE_NEEDSEP;
                        held_nibble = '0;
                    end
                end
                else if (!emit_byte({4'h0, held_nibble}))
                    raise_error(c);
                else
                begin
                    held_nibble = '0;
                    if (c == CH_NUL)
                        close_string();
                    else if (is_separator(c))
                        parse_mode = MODE_BETWEEN;
                    else
                        raise_error(c);
                end
            end
            default:
            begin
                if (c == CH_NUL)
                    close_string();
                else if (is_separator(c))
                    parse_mode = MODE_BETWEEN;
                else
                    raise_error(c);
            end
        endcase
    endfunction

    //--------------------------------------------------------------------
    // Character sender
    //--------------------------------------------------------------------
    // Offer one character and return at the edge that accepts it. Called right
    // after a falling edge; valid stays high from one transaction into the next
    // unless an idle cycle is drawn.
    task automatic offer_char(input logic [7:0] c);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            ch_bus.valid <= 1'b0;
            @(negedge clk);
        end
        ch_bus.valid <= 1'b1;
        ch_bus.ch    <= c;
        @(posedge clk);
        while (!ch_bus.ready)
            @(posedge clk);
    endtask

    // Send one character and queue what the predictor says it yields.
    task automatic send_char(input logic [7:0] c);
        offer_char(c);
        chars_sent++;
        parse_char(c);
        foreach (char_results[k])
            pending_results.push_back(char_results[k]);
        @(negedge clk);
    endtask

    // Drop valid and hold until every owed result is back, then let the
    // pipeline settle, since a character without a result may still be inside.
    task automatic drain_results();
        ch_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        max_bytes_cfg = v;
    endtask

    function automatic logic [7:0] pick_digit();
        int unsigned v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return CH_ZERO + 8'(v);
        if (v < 16)
            return CH_LOW_A + 8'(v - 10);
        return CH_UP_A + 8'(v - 16);
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_COMMA;
        endcase
    endfunction

    // Mostly well-formed strings with random content; some carry a stray
    // character after a token, a few are pure noise.
    task automatic send_random_string();
        int kind;
        int tokens;
        kind   = $urandom_range(0, 99);
        tokens = $urandom_range(0, 8);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 12))
                send_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int t = 0; t < tokens; t++)
            begin
                repeat ($urandom_range(0, 2))
                    send_char(pick_separator());
                if ($urandom_range(0, 2) == 0)
                begin
                    send_char(CH_ZERO);
                    send_char(($urandom_range(0, 1) != 0) ? CH_LOW_X : CH_UP_X);
                end
                send_char(pick_digit());
                if ($urandom_range(0, 1) != 0)
                    send_char(pick_digit());
                if (kind < 30 && $urandom_range(0, 3) == 0)
                    send_char(8'($urandom_range(1, 255)));
                // the last token may run straight into the NUL
                if (t != tokens - 1 || $urandom_range(0, 1) != 0)
                    send_char(pick_separator());
            end
        end
        send_char(CH_NUL);
    endtask

    //--------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    //--------------------------------------------------------------------
    initial
    begin
        res_bus.ready   = 1'b0;
        hold_off_served = 0;
        hold_left       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_served != hold_off_asked)
            begin
                hold_off_served = hold_off_asked;
                hold_left       = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    task automatic log_mismatch(input string why, input result_t exp_r, input result_t act_r);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected outcome=%0d byte=%02h count=%0d final=%0b",
                     $realtime, why, exp_r.outcome, exp_r.byte_value, exp_r.byte_count,
                     exp_r.final_of_string,
                     " got outcome=%0d byte=%02h count=%0d final=%0b",
                     act_r.outcome, act_r.byte_value, act_r.byte_count,
                     act_r.final_of_string);
    endtask

    // Compare every accepted result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = result_t'{res_bus.outcome, res_bus.byte_value, res_bus.byte_count,
                            res_bus.final_of_string};
            if (pending_results.size() == 0)
                log_mismatch("unexpected result", NO_RESULT, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.outcome !== want.outcome || got.byte_value !== want.byte_value
                    || got.byte_count !== want.byte_count
                    || got.final_of_string !== want.final_of_string)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    //--------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------
    initial
    begin
        int          phase;
        logic [15:0] limit_value;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        ch_bus.valid   = 1'b0;
        ch_bus.ch      = '0;
        idle_on        = 1'b1;
        hold_off_asked = 0;
        mismatch_count = 0;
        chars_sent     = 0;
        parse_mode     = MODE_BETWEEN;
        held_nibble    = '0;
        byte_total     = '0;
        max_bytes_cfg  = 16'(MAX_BYTES_RESET);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, run with the limit left at its reset value
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].typed)
            begin
                offer_char(DIRECTED_ROWS[i].ch);
                parse_char(DIRECTED_ROWS[i].ch);   // keep the predictor in step
                if (DIRECTED_ROWS[i].n_results >= 2'd1)
                    pending_results.push_back(DIRECTED_ROWS[i].first);
                if (DIRECTED_ROWS[i].n_results == 2'd2)
                    pending_results.push_back(DIRECTED_ROWS[i].second);
                @(negedge clk);
            end
            else
                send_char(DIRECTED_ROWS[i].ch);
        end

        // Random strings, cycling through limit settings. The first phase runs
        // with no idling on either side; the second starts with a long hold-off
        // of the receiver so the result queue fills and the input stalls.
        phase      = 0;
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            case (phase % 6)
                0:       limit_value = 16'hFFFF;
                1:       limit_value = 16'd0;
                2:       limit_value = 16'd1;
                3:       limit_value = 16'd3;
                4:       limit_value = 16'($urandom_range(2, 12));
                default: limit_value = 16'($urandom_range(0, 65535));
            endcase
            set_limit(limit_value);
            idle_on = (phase != 0);
            if (phase == 1)
                hold_off_asked++;
            repeat (12)
            begin
                if ($urandom_range(0, 9) == 0)
                    hold_off_asked++;
                send_random_string();
            end
            phase++;
        end

        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** hex_byte_list_parser: PASSED **");
        else
            $display("** hex_byte_list_parser: FAILED **");
        $finish;
    end

endmodule
